[rtl/core/fixed_window_rate_limiter_macros.svh]
// fixed_window_rate_limiter_macros.svh: assertion macros for the rate limiter RTL.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
`define FWRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FWRL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FWRL_ASSERT(lbl, prop, msg)
`define FWRL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/fwrl_pkg.sv]
// fwrl_pkg: field widths, register indexes, reset values and slot/result types
// for the fixed-window rate limiter. No dependencies.
package fwrl_pkg;

  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int COUNT_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIN = 2'd1;

  localparam logic [CFG_W-1:0] MAX_RESET = 16'd10;
  localparam logic [CFG_W-1:0] WIN_RESET = 16'd60;

  typedef struct packed {
    logic [TIME_W-1:0]  start;
    logic [COUNT_W-1:0] count;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic               allowed;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

[rtl/core/fixed_window_rate_limiter.sv]
// Fixed-window rate limiter, top level. A request passes stage 1, stage 2 (slot map),
// stage 3 (RAM read) and the output register; throughput one request per cycle while
// out_ready does not stall the output, set by the single read-modify-write of the slot
// RAM (same-slot hits are forwarded). Reset (synchronous): limits return to 10 and 60,
// then a clearing pass zeroes all SLOT_COUNT slots (256 by default) with in_ready low.
// Uses fwrl_pkg, fwrl_slot_map, fwrl_ram, fwrl_window and the assertion macros.
`include "fixed_window_rate_limiter_macros.svh"
module fixed_window_rate_limiter #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fwrl_pkg::ID_W-1:0]        in_identity,
  input  logic [fwrl_pkg::TIME_W-1:0]      in_now_seconds,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_allowed,
  output logic [fwrl_pkg::COUNT_W-1:0]     out_window_count
);
  import fwrl_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  logic [CFG_W-1:0] max_r;
  logic [CFG_W-1:0] win_r;

  logic              clr_r;
  logic [SLOT_W-1:0] clr_idx_r;

  logic              v1_r, v2_r, v3_r;
  logic [ID_W-1:0]   id1_r;
  logic [TIME_W-1:0] now1_r, now2_r, now3_r;
  logic [SLOT_W-1:0] slot2;
  logic [SLOT_W-1:0] slot3_r;
  logic              fwd_hit_r;
  slot_entry_t       fwd_entry_r;

  logic              out_valid_r;
  result_t           out_res_r;

  logic              out_load_ok, ready1, ready2, ready3;
  logic              in_xfer, mv12, mv23, mv3o;

  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;

  slot_entry_t       cur_entry;
  slot_entry_t       new_entry;
  result_t           res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_RESET;
      win_r <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MAX: max_r <= cfg_data;
        CFG_IDX_WIN: win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (clr_idx_r == SLOT_LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  // pipeline flow: each stage moves when the one after it can take it
  assign out_load_ok = !out_valid_r || out_ready;
  assign ready3      = !v3_r || out_load_ok;
  assign ready2      = !v2_r || ready3;
  assign ready1      = !v1_r || ready2;
  assign in_ready    = ready1 && !clr_r;
  assign in_xfer     = in_valid && in_ready;
  assign mv12        = v1_r && ready2;
  assign mv23        = v2_r && ready3;
  assign mv3o        = v3_r && out_load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_xfer;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
      if (out_load_ok) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      id1_r  <= in_identity;
      now1_r <= in_now_seconds;
    end
    if (mv12) begin
      now2_r <= now1_r;
    end
    if (mv23) begin
      now3_r      <= now2_r;
      slot3_r     <= slot2;
      // RAM read collides with this cycle's write-back: take the written entry
      fwd_hit_r   <= mv3o && (slot3_r == slot2);
      fwd_entry_r <= new_entry;
    end
    if (mv3o) begin
      out_res_r <= res;
    end
  end

  fwrl_slot_map #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slot_map (
    .clk   (clk),
    .en    (mv12),
    .id_i  (id1_r),
    .slot_o(slot2)
  );

  assign ram_wr_en   = clr_r || mv3o;
  assign ram_wr_addr = clr_r ? clr_idx_r : slot3_r;
  assign ram_wr_data = clr_r ? '0 : new_entry;

  fwrl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (mv23),
    .rd_addr(slot2),
    .rd_data(ram_rd_data)
  );

  assign cur_entry = fwd_hit_r ? fwd_entry_r : slot_entry_t'(ram_rd_data);

  fwrl_window u_window (
    .entry_i(cur_entry),
    .now_i  (now3_r),
    .max_i  (max_r),
    .win_i  (win_r),
    .entry_o(new_entry),
    .res_o  (res)
  );

  assign out_valid        = out_valid_r;
  assign out_allowed      = out_res_r.allowed;
  assign out_window_count = out_res_r.count;

  `FWRL_ASSERT(a_clear_pipe_empty, clr_r |-> (!v1_r && !v2_r && !v3_r && !out_valid_r), "request in flight during store clearing")
  `FWRL_ASSERT(a_count_nonzero, out_valid_r |-> (out_res_r.count != '0), "result count is zero")
  `FWRL_ASSERT_NEXT(a_stall_holds_slot, v3_r && !out_load_ok, v3_r && $stable(slot3_r), "stalled update stage lost its slot")

endmodule

[rtl/core/fwrl_ram.sv]
// fwrl_ram: generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module fwrl_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/fwrl_slot_map.sv]
// fwrl_slot_map: identity modulo SLOT_COUNT by reciprocal multiply, one register stage.
// Depends on fwrl_pkg for the identity width.
module fwrl_slot_map #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [fwrl_pkg::ID_W-1:0]     id_i,
  output logic [$clog2(SLOT_COUNT)-1:0] slot_o
);
  import fwrl_pkg::*;

  localparam int L      = $clog2(SLOT_COUNT);
  localparam int PROD_W = 2 * ID_W + 1;
  // ceil(2^(ID_W+L) / N): exact quotient for every ID_W-bit dividend
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (ID_W + L)) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
  localparam logic [ID_W:0]   RECIP   = RECIP_FULL[ID_W:0];
  localparam logic [ID_W-1:0] DIVISOR = ID_W'(SLOT_COUNT);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [ID_W-1:0]   q_nxt;
  logic [ID_W-1:0]   q_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   qn;
  logic [ID_W-1:0]   rem;

  assign prod    = PROD_W'(id_i) * PROD_W'(RECIP);
  assign prod_sh = prod >> (ID_W + L);
  assign q_nxt   = prod_sh[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      id_r <= id_i;
      q_r  <= q_nxt;
    end
  end

  assign qn     = q_r * DIVISOR;
  assign rem    = id_r - qn;
  assign slot_o = rem[L-1:0];

endmodule

[rtl/core/fwrl_window.sv]
// fwrl_window: window restart, saturating count and allow decision for one slot.
// Depends on fwrl_pkg for slot_entry_t and result_t.
module fwrl_window (
  input  fwrl_pkg::slot_entry_t       entry_i,
  input  logic [fwrl_pkg::TIME_W-1:0] now_i,
  input  logic [fwrl_pkg::CFG_W-1:0]  max_i,
  input  logic [fwrl_pkg::CFG_W-1:0]  win_i,
  output fwrl_pkg::slot_entry_t       entry_o,
  output fwrl_pkg::result_t           res_o
);
  import fwrl_pkg::*;

  logic [TIME_W-1:0]  elapsed;
  logic               restart;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] cnt;

  // modulo 2^32: a time before the window start reads as a huge elapsed value
  assign elapsed = now_i - entry_i.start;
  assign restart = elapsed > TIME_W'(win_i);
  assign base    = restart ? '0 : entry_i.count;
  assign cnt     = (base == COUNT_MAX) ? base : base + COUNT_W'(1);

  assign entry_o.start = restart ? now_i : entry_i.start;
  assign entry_o.count = cnt;
  assign res_o.allowed = cnt <= COUNT_W'(max_i);
  assign res_o.count   = cnt;

endmodule
